// File: design/assert_macros.svh
// Assertion macros shared by the dependency arc tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DAT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define DAT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DAT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)

`define DAT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: design/dat_pkg.sv
// Shared codes, defaults and token types of the dependency arc tracker.
package dat_pkg;

    localparam int DEFAULT_MAX_ARCS = 32;
    localparam int DEFAULT_ID_BITS  = 16;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_DONE   = 3'd2;
    localparam logic [2:0] CMD_ARM    = 3'd3;
    localparam logic [2:0] CMD_LOOKUP = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_RESERVED = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [2:0] cmd;
        logic       rsv;
        logic       wk;
        logic       dn;
        logic       found;
        logic       ins;
        logic       newly;
        logic       fwk;
        logic       fdn;
    } tok_ctrl_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] slot;
        logic       ready;
        logic       wk;
        logic       done;
        logic [5:0] waiting;
    } res_t;

endpackage

// File: design/dat_cell.sv
// One arc cell: holds one table entry and passes the command token to the next cell.
module dat_cell #(
    parameter int INDEX   = 0,
    parameter int ID_BITS = dat_pkg::DEFAULT_ID_BITS,
    parameter int IDX_W   = 5,
    parameter int CNT_W   = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dat_pkg::tok_ctrl_t   ctrl_in,
    input  logic [ID_BITS-1:0]   id_in,
    input  logic [CNT_W-1:0]     cnt_in,
    input  logic [IDX_W-1:0]     slot_in,
    output dat_pkg::tok_ctrl_t   ctrl_out,
    output logic [ID_BITS-1:0]   id_out,
    output logic [CNT_W-1:0]     cnt_out,
    output logic [IDX_W-1:0]     slot_out
);

    localparam logic [CNT_W-1:0] POS  = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] SPOS = IDX_W'(INDEX);

    logic [ID_BITS-1:0]  id_reg;
    logic                weak_reg;
    logic                done_reg;
    logic                weak_next;
    logic                done_next;
    logic                write_en;
    dat_pkg::tok_ctrl_t  ctrl_reg;
    dat_pkg::tok_ctrl_t  ctrl_next;
    logic [ID_BITS-1:0]  tid_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    slot_next;
    logic                occupied;
    logic                match;

    assign occupied = POS < cnt_in;
    assign match    = ctrl_in.valid && !ctrl_in.found && occupied && (id_reg == id_in);

    always_comb begin
        ctrl_next = ctrl_in;
        slot_next = slot_in;
        weak_next = weak_reg;
        done_next = done_reg;
        write_en  = 1'b0;
        if (ctrl_in.valid) begin
            case (ctrl_in.cmd)
                dat_pkg::CMD_ADD, dat_pkg::CMD_APPEND: begin
                    if (!ctrl_in.rsv) begin
                        if (ctrl_in.cmd == dat_pkg::CMD_ADD && match) begin
                            weak_next       = weak_reg & ctrl_in.wk;
                            ctrl_next.found = 1'b1;
                            ctrl_next.fwk   = weak_reg & ctrl_in.wk;
                            ctrl_next.fdn   = done_reg;
                            slot_next       = SPOS;
                        end else if (!ctrl_in.found && POS == cnt_in) begin
                            write_en        = 1'b1;
                            weak_next       = ctrl_in.wk;
                            done_next       = ctrl_in.dn;
                            ctrl_next.found = 1'b1;
                            ctrl_next.ins   = 1'b1;
                            ctrl_next.fwk   = ctrl_in.wk;
                            ctrl_next.fdn   = ctrl_in.dn;
                            slot_next       = SPOS;
                        end
                    end
                end
                dat_pkg::CMD_DONE: begin
                    if (match) begin
                        done_next       = 1'b1;
                        ctrl_next.found = 1'b1;
                        ctrl_next.newly = !done_reg;
                        ctrl_next.fwk   = weak_reg;
                        ctrl_next.fdn   = 1'b1;
                        slot_next       = SPOS;
                    end
                end
                dat_pkg::CMD_ARM: begin
                    if (occupied) begin
                        done_next = 1'b0;
                    end
                end
                dat_pkg::CMD_LOOKUP: begin
                    if (match) begin
                        ctrl_next.found = 1'b1;
                        ctrl_next.fwk   = weak_reg;
                        ctrl_next.fdn   = done_reg;
                        slot_next       = SPOS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
        tid_reg  <= id_in;
        cnt_reg  <= cnt_in;
        slot_reg <= slot_next;
        weak_reg <= weak_next;
        done_reg <= done_next;
        if (write_en) begin
            id_reg <= id_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign id_out   = tid_reg;
    assign cnt_out  = cnt_reg;
    assign slot_out = slot_reg;

endmodule

// File: design/dependency_arc_tracker.sv
// Top level of the dependency arc tracker: command launch, cell chain and result queue.
//
//   channel  direction  ports                                     word
//   s_       in         s_valid s_ready                           cmd, node id, flags
//   m_       out        m_valid m_ready                           status, slot, flags, waiting
//
// A command word walks the cell chain one cell per cycle. Its result is registered
// when the token leaves the last cell, and the next word is taken only after that
// and only while the hold register is empty.
// Reset clears the arc count, the waiting count and all token and handshake state.
// One finished result can wait in a hold register behind the output register, so
// the input is accepted while m_ready is low until both are full.
module dependency_arc_tracker #(
    parameter int MAX_ARCS = dat_pkg::DEFAULT_MAX_ARCS,
    parameter int ID_BITS  = dat_pkg::DEFAULT_ID_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [15:0] s_node_id,
    input  logic        s_weak_flag,
    input  logic        s_done_flag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_slot,
    output logic        m_became_ready,
    output logic        m_is_weak,
    output logic        m_is_done,
    output logic [5:0]  m_waiting_left
);

    localparam int IDX_W = $clog2(MAX_ARCS);
    localparam int CNT_W = $clog2(MAX_ARCS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ARCS);

    dat_pkg::tok_ctrl_t  tok_ctrl [MAX_ARCS+1];
    logic [ID_BITS-1:0]  tok_id   [MAX_ARCS+1];
    logic [CNT_W-1:0]    tok_cnt  [MAX_ARCS+1];
    logic [IDX_W-1:0]    tok_slot [MAX_ARCS+1];

    dat_pkg::tok_ctrl_t  launch_reg;
    dat_pkg::tok_ctrl_t  launch_next;
    logic [ID_BITS-1:0]  launch_id_reg;
    logic [ID_BITS-1:0]  in_id;
    logic                busy_reg;
    logic [CNT_W-1:0]    arc_count_reg;
    logic [CNT_W-1:0]    arc_count_next;
    logic [CNT_W-1:0]    waiting_reg;
    logic [CNT_W-1:0]    waiting_next;
    dat_pkg::res_t       out_reg;
    dat_pkg::res_t       hold_reg;
    dat_pkg::res_t       res;
    logic                m_valid_reg;
    logic                hold_valid_reg;
    logic                accept;
    logic                finish;
    dat_pkg::tok_ctrl_t  fin;

    assign in_id   = ID_BITS'(32'(s_node_id));
    assign s_ready = !busy_reg && !hold_valid_reg;
    assign accept  = s_valid && s_ready;
    assign fin     = tok_ctrl[MAX_ARCS];
    assign finish  = fin.valid;

    always_comb begin
        launch_next       = '0;
        launch_next.valid = accept;
        launch_next.cmd   = s_cmd;
        launch_next.rsv   = (in_id == '1);
        launch_next.wk    = s_weak_flag;
        launch_next.dn    = s_done_flag;
    end

    assign tok_ctrl[0] = launch_reg;
    assign tok_id[0]   = launch_id_reg;
    assign tok_cnt[0]  = arc_count_reg;
    assign tok_slot[0] = '0;

    for (genvar g = 0; g < MAX_ARCS; g++) begin : g_cell
        dat_cell #(
            .INDEX   (g),
            .ID_BITS (ID_BITS),
            .IDX_W   (IDX_W),
            .CNT_W   (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl_in  (tok_ctrl[g]),
            .id_in    (tok_id[g]),
            .cnt_in   (tok_cnt[g]),
            .slot_in  (tok_slot[g]),
            .ctrl_out (tok_ctrl[g+1]),
            .id_out   (tok_id[g+1]),
            .cnt_out  (tok_cnt[g+1]),
            .slot_out (tok_slot[g+1])
        );
    end

    always_comb begin
        arc_count_next = arc_count_reg;
        waiting_next   = waiting_reg;
        res            = '0;
        res.status     = dat_pkg::STAT_OK;
        case (fin.cmd)
            dat_pkg::CMD_ADD, dat_pkg::CMD_APPEND: begin
                if (fin.rsv) begin
                    res.status = dat_pkg::STAT_RESERVED;
                end else if (fin.found) begin
                    res.slot = 5'(tok_slot[MAX_ARCS]);
                    res.wk   = fin.fwk;
                    res.done = fin.fdn;
                    if (fin.ins) begin
                        arc_count_next = arc_count_reg + CNT_W'(1);
                    end
                end else begin
                    res.status = dat_pkg::STAT_FULL;
                end
            end
            dat_pkg::CMD_DONE: begin
                if (fin.found) begin
                    if (fin.newly && waiting_reg != '0) begin
                        waiting_next = waiting_reg - CNT_W'(1);
                    end
                    res.slot  = 5'(tok_slot[MAX_ARCS]);
                    res.ready = fin.newly && (waiting_next == '0);
                    res.wk    = fin.fwk;
                    res.done  = fin.fdn;
                end else begin
                    res.status = dat_pkg::STAT_NOTFOUND;
                end
            end
            dat_pkg::CMD_ARM: begin
                waiting_next = arc_count_reg;
            end
            dat_pkg::CMD_LOOKUP: begin
                if (fin.found) begin
                    res.slot = 5'(tok_slot[MAX_ARCS]);
                    res.wk   = fin.fwk;
                    res.done = fin.fdn;
                end else begin
                    res.status = dat_pkg::STAT_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
        res.waiting = 6'(waiting_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_reg     <= '0;
            busy_reg       <= 1'b0;
            arc_count_reg  <= '0;
            waiting_reg    <= '0;
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            launch_reg <= launch_next;
            if (accept) begin
                busy_reg <= 1'b1;
            end
            if (finish) begin
                busy_reg      <= 1'b0;
                arc_count_reg <= arc_count_next;
                waiting_reg   <= waiting_next;
                if (!m_valid_reg || m_ready) begin
                    out_reg     <= res;
                    m_valid_reg <= 1'b1;
                end else begin
                    hold_reg       <= res;
                    hold_valid_reg <= 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                if (hold_valid_reg) begin
                    out_reg        <= hold_reg;
                    hold_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
        if (accept) begin
            launch_id_reg <= in_id;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_slot         = out_reg.slot;
    assign m_became_ready = out_reg.ready;
    assign m_is_weak      = out_reg.wk;
    assign m_is_done      = out_reg.done;
    assign m_waiting_left = out_reg.waiting;

`include "assert_macros.svh"

    `DAT_ASSERT_IMPL(a_hold_out, aclk, aresetn, hold_valid_reg, m_valid_reg, "stray hold word")
    `DAT_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, busy_reg, "walk not started")
    `DAT_ASSERT_IMPL(a_cnt_max, aclk, aresetn, 1'b1, arc_count_reg <= CNT_MAX, "count overflow")
    `DAT_ASSERT_IMPL(a_wait, aclk, aresetn, 1'b1, waiting_reg <= arc_count_reg, "wait overflow")

endmodule
